// File: hdl/rdm_disc_pkg.sv
// ----------------------------------------------------------------------------
// RDM discovery reply decoder package
// Shared types and constants for the discovery-branch reply decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rdm_disc_pkg;

    localparam logic [7:0] PREAMBLE_BYTE  = 8'hFE;
    localparam logic [7:0] SEPARATOR_BYTE = 8'hAA;
    localparam logic [7:0] LOW_MASK       = 8'h55;
    localparam logic [7:0] HIGH_MASK      = 8'hAA;

    localparam int UID_W       = 48;
    localparam int COUNT_W     = 4;
    localparam logic [COUNT_W-1:0] ENCODED_BYTES = 4'd12;

    typedef enum logic [1:0] {
        ST_NONE      = 2'd0,
        ST_COLLISION = 2'd1,
        ST_FOUND     = 2'd2
    } status_t;

    typedef enum logic {
        PH_PREAMBLE = 1'b0,
        PH_DATA     = 1'b1
    } phase_t;

    // one received item as held in the input register
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_of_frame;
        logic       frame_empty;
    } item_t;

    // one decode result
    typedef struct packed {
        status_t          status;
        logic [UID_W-1:0] found_uid;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/rdm_disc_in_stage.sv
// ----------------------------------------------------------------------------
// RDM discovery input register
// Registers one request from the input channel; stalls while it cannot move on.
// ----------------------------------------------------------------------------
`default_nettype none

module rdm_disc_in_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire rdm_disc_pkg::item_t in_item,
    input  wire logic                advance,
    output logic                     held_valid,
    output rdm_disc_pkg::item_t      held_item
);
    import rdm_disc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // stall only while a held request cannot advance
    assign in_stall = valid_reg && !advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (!in_stall)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

// File: hdl/rdm_disc_decode.sv
// ----------------------------------------------------------------------------
// RDM discovery frame decoder
// Tracks preamble/data phase, pairs data bytes into UID bytes, forms result.
// ----------------------------------------------------------------------------
`default_nettype none

module rdm_disc_decode (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rdm_disc_pkg::item_t item,
    input  wire logic                step,
    output logic                     res_produce,
    output rdm_disc_pkg::result_t    res
);
    import rdm_disc_pkg::*;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [7:0]         pair_reg;
    logic [7:0]         pair_next;
    logic [UID_W-1:0]   uid_reg;
    logic [UID_W-1:0]   uid_next;
    logic               take;
    logic [7:0]         dec_byte;

    assign res_produce = item.last_of_frame || item.frame_empty;
    assign dec_byte    = (pair_reg & LOW_MASK) | (item.byte_value & HIGH_MASK);

    // per-byte state update
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        pair_next  = pair_reg;
        uid_next   = uid_reg;
        take       = 1'b0;
        if (phase_reg == PH_PREAMBLE)
        begin
            if (item.byte_value != PREAMBLE_BYTE)
            begin
                phase_next = PH_DATA;
                take       = (item.byte_value != SEPARATOR_BYTE);
            end
        end
        else
        begin
            take = 1'b1;
        end
        if (take && (count_reg < ENCODED_BYTES))
        begin
            if (!count_reg[0])
            begin
                pair_next = item.byte_value;
            end
            else
            begin
                uid_next = {uid_reg[UID_W-9:0], dec_byte};
            end
            count_next = count_reg + COUNT_W'(1);
        end
    end

    // result from the updated count
    always_comb
    begin
        res.status    = ST_NONE;
        res.found_uid = '0;
        if (!item.frame_empty)
        begin
            if (count_next == '0)
            begin
                res.status = ST_NONE;
            end
            else if (count_next < ENCODED_BYTES)
            begin
                res.status = ST_COLLISION;
            end
            else
            begin
                res.status    = ST_FOUND;
                res.found_uid = uid_next;
            end
        end
    end

    // state registers; cleared after every frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREAMBLE;
            count_reg <= '0;
            pair_reg  <= '0;
            uid_reg   <= '0;
        end
        else if (step)
        begin
            if (res_produce)
            begin
                phase_reg <= PH_PREAMBLE;
                count_reg <= '0;
                pair_reg  <= '0;
                uid_reg   <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                pair_reg  <= pair_next;
                uid_reg   <= uid_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/rdm_disc_out_stage.sv
// ----------------------------------------------------------------------------
// RDM discovery result register
// Holds one result until the output channel takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rdm_disc_out_stage (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire rdm_disc_pkg::result_t res_in,
    output logic                       free,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output rdm_disc_pkg::result_t      res_out
);
    import rdm_disc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // register can take a new result when empty or being drained
    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

`default_nettype wire

// File: hdl/rdm_discovery_response_decoder.sv
// Path: a request enters the input register; its frame result enters the result register.
// Throughput: one byte request per cycle while results are not held up by out_stall,
// set by the single-pass decode between the input register and the result register.
// Reset: asynchronous active-low rst_n clears both valid flags and returns the
// frame state to preamble with zero count and UID.
// ----------------------------------------------------------------------------
// RDM discovery response decoder
// Decodes a discovery-branch reply, one byte per request, into a UID status.
// ----------------------------------------------------------------------------
`default_nettype none

module rdm_discovery_response_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  byte_value,
    input  wire logic        last_of_frame,
    input  wire logic        frame_empty,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [47:0]      found_uid
);
    import rdm_disc_pkg::*;

    item_t   in_item;
    item_t   held_item;
    logic    held_valid;
    logic    advance;
    logic    res_produce;
    logic    out_free;
    result_t dec_res;
    result_t out_res;

    assign in_item.byte_value    = byte_value;
    assign in_item.last_of_frame = last_of_frame;
    assign in_item.frame_empty   = frame_empty;

    // held request moves on unless its result has nowhere to go
    assign advance = held_valid && (!res_produce || out_free);

    rdm_disc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    rdm_disc_decode u_dec (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (held_item),
        .step        (advance),
        .res_produce (res_produce),
        .res         (dec_res)
    );

    rdm_disc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_produce),
        .res_in    (dec_res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (out_res)
    );

    assign status    = out_res.status;
    assign found_uid = out_res.found_uid;

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Discovery reply decoder testbench
// Feeds reply bytes, empty receives and noise frames through the decoder
// under random input gaps and output stalls, predicts each UID status in a
// scoreboard and checks every result against it in order.
// ----------------------------------------------------------------------------

module tb;

    import rdm_disc_pkg::*;

    // Predicts decoder results and holds them until they come out
    class uid_decode_model;
        phase_t             phase_q;
        logic [COUNT_W-1:0] count_q;
        logic [7:0]         first_q;
        logic [UID_W-1:0]   uid_q;
        result_t            replies[$];
        int                 mismatches;

        function new();
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            phase_q = PH_PREAMBLE;
            count_q = '0;
            first_q = '0;
            uid_q   = '0;
        endfunction

        // queue one expected result at the tail
        function void queue_reply(result_t r);
            replies.insert(replies.size(), r);
        endfunction

        // one data byte: pairs fold into a UID byte, count saturates
        function void take_data(logic [7:0] b);
            if (count_q >= ENCODED_BYTES)
            begin
                return;
            end
            if (!count_q[0])
            begin
                first_q = b;
            end
            else
            begin
                uid_q = {uid_q[UID_W-9:0], (first_q & LOW_MASK) | (b & HIGH_MASK)};
            end
            count_q = count_q + 1'b1;
        endfunction

        // accepted request: advance the frame and queue a result at frame end
        function void take_request(logic [7:0] b, logic last, logic empty);
            result_t r;
            r.status    = ST_NONE;
            r.found_uid = '0;
            if (empty)
            begin
                queue_reply(r);
                clear_frame();
                return;
            end
            if (phase_q == PH_PREAMBLE)
            begin
                if (b != PREAMBLE_BYTE)
                begin
                    phase_q = PH_DATA;
                    if (b != SEPARATOR_BYTE)
                    begin
                        take_data(b);
                    end
                end
            end
            else
            begin
                take_data(b);
            end
            if (!last)
            begin
                return;
            end
            if (count_q == 0)
            begin
                r.status = ST_NONE;
            end
            else if (count_q < ENCODED_BYTES)
            begin
                r.status = ST_COLLISION;
            end
            else
            begin
                r.status    = ST_FOUND;
                r.found_uid = uid_q;
            end
            queue_reply(r);
            clear_frame();
        endfunction

        function void check_reply(logic [1:0] st, logic [UID_W-1:0] uid);
            result_t want;
            if (replies.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got status %0d uid %012h",
                         $time, st, uid);
                mismatches++;
                return;
            end
            want = replies.pop_front();
            if (st !== want.status)
            begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, st);
                mismatches++;
            end
            if (uid !== want.found_uid)
            begin
                $display("%0t: found_uid expected %012h, got %012h",
                         $time, want.found_uid, uid);
                mismatches++;
            end
        endfunction

        function int pending();
            return replies.size();
        endfunction
    endclass

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              in_valid      = 1'b0;
    logic              in_stall;
    logic [7:0]        byte_value    = 8'h00;
    logic              last_of_frame = 1'b0;
    logic              frame_empty   = 1'b0;
    logic              out_valid;
    logic              out_stall     = 1'b0;
    logic [1:0]        status;
    logic [UID_W-1:0]  found_uid;

    uid_decode_model   sb = new();
    int                items_sent = 0;
    int                burst_left = 0;
    int                rx_cycle   = 0;
    int                hold_left  = 0;
    rx_mode_t          rx_mode    = RX_FREE;
    logic              long_hold;

    assign long_hold = (hold_left != 0);

    rdm_discovery_response_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .byte_value    (byte_value),
        .last_of_frame (last_of_frame),
        .frame_empty   (frame_empty),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .found_uid     (found_uid)
    );

    always #4 clk = ~clk;

    // Watch both handshakes at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sb.take_request(byte_value, last_of_frame, frame_empty);
            end
            if (out_valid && !out_stall)
            begin
                sb.check_reply(status, found_uid);
            end
        end
    end

    // Receiver: switches among free, light, heavy and toggling stall patterns, with a recurring long hold-off
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (rx_cycle % 1000 == 400)
        begin
            hold_left <= 200;
            out_stall <= 1'b1;
        end
        else
        begin
            if (rx_cycle % 64 == 0)
            begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
            end
            case (rx_mode)
                RX_FREE:   out_stall <= 1'b0;
                RX_LIGHT:  out_stall <= ($urandom_range(0, 9) < 3);
                RX_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
                default:   out_stall <= ~out_stall;
            endcase
        end
    end

    // Offer one request and wait for it; idle between bursts
    task automatic send_item(input logic [7:0] b, input logic last, input logic empty);
        in_valid      <= 1'b1;
        byte_value    <= b;
        last_of_frame <= last;
        frame_empty   <= empty;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
        burst_left--;
        // keep offering while the receiver is held off so the pipe backs up
        if (burst_left <= 0 && !long_hold)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // Reply frame: preamble, optional separator, random data bytes; an empty receive if all counts are zero
    task automatic send_reply(input int n_pre, input bit sep, input int n_data);
        int          total;
        logic [7:0]  b;
        total = n_pre + sep + n_data;
        if (total == 0)
        begin
            send_item($urandom_range(0, 255), $urandom_range(0, 1), 1'b1);
            return;
        end
        for (int i = 0; i < total; i++)
        begin
            if (i < n_pre)
            begin
                b = PREAMBLE_BYTE;
            end
            else if (sep && i == n_pre)
            begin
                b = SEPARATOR_BYTE;
            end
            else
            begin
                b = $urandom_range(0, 255);
            end
            send_item(b, i == total - 1, 1'b0);
        end
    endtask

    initial
    begin
        int          pick;
        logic [7:0]  uid_bytes[12];
        uid_bytes = '{8'hFF, 8'h00, 8'hFE, 8'hAA, 8'h55, 8'hAA,
                      8'h00, 8'hFF, 8'h12, 8'h34, 8'hAB, 8'hCD};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst_left = $urandom_range(1, 24);

        // Directed: empty receive, bare preamble, bare separator
        send_item(8'h00, 1'b0, 1'b1);
        send_item(PREAMBLE_BYTE, 1'b1, 1'b0);
        send_item(SEPARATOR_BYTE, 1'b1, 1'b0);
        // full reply; separator lets 0xFE and 0xAA through as data
        send_item(PREAMBLE_BYTE, 1'b0, 1'b0);
        send_item(PREAMBLE_BYTE, 1'b0, 1'b0);
        send_item(SEPARATOR_BYTE, 1'b0, 1'b0);
        for (int i = 0; i < 12; i++)
        begin
            send_item(uid_bytes[i], i == 11, 1'b0);
        end
        // short replies without preamble give collisions
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        // partial frame dropped by an empty receive
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h3C, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);

        // Random: mostly well-formed replies, some collisions and noise
        while (items_sent < 825)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                send_reply($urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(12, 16));
            end
            else if (pick < 80)
            begin
                send_reply($urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(1, 11));
            end
            else if (pick < 88)
            begin
                send_reply($urandom_range(0, 3), $urandom_range(0, 1), 0);
            end
            else
            begin
                repeat ($urandom_range(1, 10))
                begin
                    send_item($urandom_range(0, 255), $urandom_range(0, 3) == 0,
                              $urandom_range(0, 9) == 0);
                end
            end
        end
        in_valid <= 1'b0;

        // Drain, then give the pipe time to show any stray result
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Run limit
    initial
    begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
